### design/bed_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bed_pkg: binary erosion disk types and constants
// Beat payloads, register index codes and the fixed field widths of the
// register port.
// -----------------------------------------------------------------------------
package bed_pkg;

   // register port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISK_RADIUS  = 2'd2;

   // register fields
   localparam int WIDTH_BITS        = 12;
   localparam int HEIGHT_BITS       = 12;
   localparam int RADIUS_FIELD_BITS = 4;
   localparam int ROW_BITS          = 11;
   localparam int MAX_HEIGHT        = 2048;
   localparam int WIDTH_DEFAULT     = 2048;
   localparam int HEIGHT_DEFAULT    = 2048;
   localparam int RADIUS_DEFAULT    = 6;

   typedef struct packed {
      logic pixel_in;
      logic filler;
   } req_type;

   typedef struct packed {
      logic pixel_out;
      logic frame_last;
   } rsp_type;

endpackage
`default_nettype wire

### design/bed_line_store.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bed_line_store: column history memory
// One word per image column holding the previous rows of that column, one bit
// per row. One write and one registered read per clock.
// -----------------------------------------------------------------------------
module bed_line_store #(
   parameter int DEPTH     = 2048,
   parameter int DATA_BITS = 16,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] store_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/bed_cell.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bed_cell: one column of the erosion window
// Holds one pixel column of the window, passes it to the next cell on each
// shift, and checks it against its slice of the disk.
// -----------------------------------------------------------------------------
module bed_cell #(
   parameter int ROWS        = 17,
   parameter int RADIUS_BITS = 4,
   parameter int POSITION    = 0
) (
   input  wire logic                   clock,
   input  wire logic                   shift_en,
   input  wire logic [RADIUS_BITS-1:0] radius,
   input  wire logic [ROWS-1:0]        column_in,
   output logic      [ROWS-1:0]        column_out,
   output logic                        hit
);

   localparam int OFF_BITS = $clog2(ROWS + 1);
   localparam int SQ_BITS  = 2 * OFF_BITS;
   localparam logic [OFF_BITS-1:0] SPOT = OFF_BITS'(POSITION);

   logic [ROWS-1:0] column_ff;
   logic [ROWS-1:0] mask_ff;
   logic [ROWS-1:0] mask_in;

   // disk slice for this column: (k-r)^2 + (j-r)^2 <= r^2
   always_comb begin
      logic [OFF_BITS-1:0] rad_ext;
      logic [OFF_BITS-1:0] col_off;
      logic [OFF_BITS-1:0] row_idx;
      logic [OFF_BITS-1:0] row_off;
      logic [SQ_BITS-1:0]  col_sq;
      logic [SQ_BITS-1:0]  row_sq;
      logic [SQ_BITS-1:0]  rad_sq;
      logic [SQ_BITS:0]    dist_sq;
      rad_ext = OFF_BITS'(radius);
      col_off = (SPOT >= rad_ext) ? SPOT - rad_ext : rad_ext - SPOT;
      col_sq  = col_off * col_off;
      rad_sq  = rad_ext * rad_ext;
      for (int j = 0; j < ROWS; j++) begin
         row_idx    = OFF_BITS'(j);
         row_off    = (row_idx >= rad_ext) ? row_idx - rad_ext : rad_ext - row_idx;
         row_sq     = row_off * row_off;
         dist_sq    = {1'b0, col_sq} + {1'b0, row_sq};
         mask_in[j] = (dist_sq <= {1'b0, rad_sq});
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (shift_en) begin
         column_ff <= column_in;
      end
   end

   assign column_out = column_ff;
   assign hit        = &(column_ff | ~mask_ff);

endmodule
`default_nettype wire

### design/binary_erosion_disk_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// binary_erosion_disk_unit: binary erosion with a disk structuring element
// Raster-order pixel stream in, eroded pixel stream out.
// -----------------------------------------------------------------------------
// Takes one pixel per clock and gives one eroded pixel per clock once the
// window has filled and rsp_ready does not stall the output; a result goes
// via stage 1 and the window cells to the output register. Results lag the input by
// disk_radius * image_width + disk_radius beats, so that many filler beats
// after a frame flush it out, the last result carrying frame_last. The rate
// is set by the column memory, which is read and rewritten once per beat at
// the pixel's column (with a bypass when consecutive beats hit the same
// column), and by the chain of 2*MAX_RADIUS+1 window cells that shift once per
// beat. Pixels beyond the image border count as background. The memory needs
// no clearing after reset. A write to any of the three registers restarts the frame.
// -----------------------------------------------------------------------------
module binary_erosion_disk_unit
   import bed_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_RADIUS = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int RADIUS_BITS  = $clog2(MAX_RADIUS + 1);
   localparam int ROWS         = 2 * MAX_RADIUS + 1;
   localparam int STORE_BITS   = 2 * MAX_RADIUS;
   localparam int LAG_MAX      = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
   localparam int LAG_BITS     = $clog2(LAG_MAX + 1);
   localparam int SPAN_BITS    = WIDTH_BITS + 1;
   localparam int RCMP_BITS    = RADIUS_FIELD_BITS + 1;
   localparam int WIDTH_RESET  = (MAX_WIDTH < WIDTH_DEFAULT) ? MAX_WIDTH : WIDTH_DEFAULT;
   localparam int RADIUS_RESET = (MAX_RADIUS < RADIUS_DEFAULT) ? MAX_RADIUS : RADIUS_DEFAULT;

   typedef struct packed {
      logic emit;
      logic last;
      logic fit;
   } tag_type;

   // configuration
   logic [WIDTH_BITS-1:0]  image_width_ff,  image_width_in;
   logic [HEIGHT_BITS-1:0] image_height_ff, image_height_in;
   logic [RADIUS_BITS-1:0] radius_ff,       radius_in;
   logic [WIDTH_BITS-1:0]  width_clamp;
   logic [HEIGHT_BITS-1:0] height_clamp;
   logic [RADIUS_BITS-1:0] radius_clamp;
   logic                   restart;

   // stream position
   logic [COL_BITS-1:0] in_col_ff,  in_col_in;
   logic [LAG_BITS-1:0] lead_ff,    lead_in;
   logic [COL_BITS-1:0] out_col_ff, out_col_in;
   logic [ROW_BITS-1:0] out_row_ff, out_row_in;

   logic [RADIUS_BITS+WIDTH_BITS-1:0] lag_prod;
   logic [LAG_BITS-1:0]    lag;
   logic [WIDTH_BITS-1:0]  width_last;
   logic [HEIGHT_BITS-1:0] height_last;
   logic                   emit;
   logic                   out_col_end;
   logic                   out_row_end;
   logic                   in_col_end;
   logic                   frame_end;
   logic                   fit;
   logic                   accept;
   logic                   pixel_value;

   // pipeline
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_pix_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   tag_type               s1_tag_ff;
   logic                  byp_hit_ff;
   logic [STORE_BITS-1:0] byp_data_ff;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_last_ff;
   logic                  s2_fit_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   logic                  out_free;
   logic                  s2_adv;
   logic                  s2_open;
   logic                  s1_adv;
   logic                  s1_open;
   logic [STORE_BITS-1:0] rd_data;
   logic [STORE_BITS-1:0] stored;
   logic [STORE_BITS-1:0] wr_data;
   logic [ROWS-1:0]       col_vec;
   logic [ROWS-1:0]       chain [ROWS];
   logic [ROWS-1:0]       hits;

   // ---------------------------------------------------------------- registers
   always_comb begin
      width_clamp = WIDTH_BITS'(csr_wdata);
      if (csr_wdata == '0) begin
         width_clamp = WIDTH_BITS'(1);
      end else if (SPAN_BITS'(csr_wdata) > SPAN_BITS'(MAX_WIDTH)) begin
         width_clamp = WIDTH_BITS'(MAX_WIDTH);
      end

      height_clamp = HEIGHT_BITS'(csr_wdata);
      if (csr_wdata == '0) begin
         height_clamp = HEIGHT_BITS'(1);
      end else if (SPAN_BITS'(csr_wdata) > SPAN_BITS'(MAX_HEIGHT)) begin
         height_clamp = HEIGHT_BITS'(MAX_HEIGHT);
      end

      if (RCMP_BITS'(csr_wdata[RADIUS_FIELD_BITS-1:0]) > RCMP_BITS'(MAX_RADIUS)) begin
         radius_clamp = RADIUS_BITS'(MAX_RADIUS);
      end else begin
         radius_clamp = RADIUS_BITS'(csr_wdata[RADIUS_FIELD_BITS-1:0]);
      end
   end

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      radius_in       = radius_ff;
      restart         = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_in = width_clamp;
               restart        = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = height_clamp;
               restart         = 1'b1;
            end
            CSR_DISK_RADIUS: begin
               radius_in = radius_clamp;
               restart   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // ----------------------------------------------------------- input stage
   assign lag_prod    = radius_ff * image_width_ff;
   assign lag         = LAG_BITS'(lag_prod) + LAG_BITS'(radius_ff);
   assign width_last  = image_width_ff - 1'b1;
   assign height_last = image_height_ff - 1'b1;

   // output starts once the stream has run the lag ahead of the centre pixel
   assign emit        = (lead_ff == lag);
   assign out_col_end = (SPAN_BITS'(out_col_ff) == SPAN_BITS'(width_last));
   assign out_row_end = (SPAN_BITS'(out_row_ff) == SPAN_BITS'(height_last));
   assign in_col_end  = (SPAN_BITS'(in_col_ff) == SPAN_BITS'(width_last));
   assign frame_end   = emit && out_col_end && out_row_end;

   // the disk lies wholly inside the image, else the result is background
   assign fit = (SPAN_BITS'(out_col_ff) >= SPAN_BITS'(radius_ff))
             && (SPAN_BITS'(out_col_ff) + SPAN_BITS'(radius_ff) <= SPAN_BITS'(width_last))
             && (SPAN_BITS'(out_row_ff) >= SPAN_BITS'(radius_ff))
             && (SPAN_BITS'(out_row_ff) + SPAN_BITS'(radius_ff) <= SPAN_BITS'(height_last));

   assign accept      = req_valid && req_ready;
   assign pixel_value = req_data.pixel_in && !req_data.filler;

   always_comb begin
      in_col_in  = in_col_ff;
      lead_in    = lead_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         in_col_in  = '0;
         lead_in    = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (frame_end) begin
            in_col_in  = '0;
            lead_in    = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            in_col_in = in_col_end ? '0 : in_col_ff + 1'b1;
            if (!emit) begin
               lead_in = lead_ff + 1'b1;
            end else begin
               out_col_in = out_col_end ? '0 : out_col_ff + 1'b1;
               if (out_col_end) begin
                  out_row_in = out_row_ff + 1'b1;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------ flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = s2_valid_ff && out_free;
   assign s2_open   = !s2_valid_ff || out_free;
   assign s1_adv    = s1_valid_ff && s2_open;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign req_ready = s1_open;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = s1_tag_ff.emit;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s2_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------ column history
   bed_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (STORE_BITS),
      .ADDR_BITS (COL_BITS)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data)
   );

   // bit j of a column is the pixel j rows above in the stream
   assign stored  = byp_hit_ff ? byp_data_ff : rd_data;
   assign col_vec = {stored, s1_pix_ff};
   assign wr_data = {stored[STORE_BITS-2:0], s1_pix_ff};

   // ---------------------------------------------------------- window cells
   assign chain[0] = col_vec;

   for (genvar k = 0; k < ROWS; k++) begin : g_cell
      if (k == ROWS - 1) begin : g_tail
         bed_cell #(
            .ROWS        (ROWS),
            .RADIUS_BITS (RADIUS_BITS),
            .POSITION    (k)
         ) u_cell (
            .clock      (clock),
            .shift_en   (s1_adv),
            .radius     (radius_ff),
            .column_in  (chain[k]),
            .column_out (),
            .hit        (hits[k])
         );
      end else begin : g_body
         bed_cell #(
            .ROWS        (ROWS),
            .RADIUS_BITS (RADIUS_BITS),
            .POSITION    (k)
         ) u_cell (
            .clock      (clock),
            .shift_en   (s1_adv),
            .radius     (radius_ff),
            .column_in  (chain[k]),
            .column_out (chain[k+1]),
            .hit        (hits[k])
         );
      end
   end

   // --------------------------------------------------------------- state
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_BITS'(WIDTH_RESET);
         image_height_ff <= HEIGHT_BITS'(HEIGHT_DEFAULT);
         radius_ff       <= RADIUS_BITS'(RADIUS_RESET);
         in_col_ff       <= '0;
         lead_ff         <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         radius_ff       <= radius_in;
         in_col_ff       <= in_col_in;
         lead_ff         <= lead_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= pixel_value;
         s1_col_ff      <= in_col_ff;
         s1_tag_ff.emit <= emit;
         s1_tag_ff.last <= frame_end;
         s1_tag_ff.fit  <= fit;
         // same column rewritten on this edge: take the new word
         byp_hit_ff     <= s1_adv && (s1_col_ff == in_col_ff);
         byp_data_ff    <= wr_data;
      end
      if (s1_adv) begin
         s2_last_ff <= s1_tag_ff.last;
         s2_fit_ff  <= s1_tag_ff.fit;
      end
      if (s2_adv) begin
         rsp_data_ff.pixel_out  <= (&hits) && s2_fit_ff;
         rsp_data_ff.frame_last <= s2_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
